>>> sv/dda_pkg.sv
// ----------------------------------------------------------------------------
// DDA line stepper package
// Shared field widths, screen geometry, item payload types and the command
// and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package dda_pkg;

  // Field widths of the input and result items.
  localparam int X_W    = 10;
  localparam int Y_W    = 9;
  localparam int ADDR_W = 19;
  localparam int STEP_W = 10;

  // Screen width used for the framebuffer address.
  localparam int SCREEN_COLUMNS = 640;

  // Default number of fraction bits of the fixed-point position.
  localparam int FRACTION_BITS_DEF = 16;

  // Item modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef struct packed {
    logic           mode;
    logic [X_W-1:0] start_x;
    logic [Y_W-1:0] start_y;
    logic [X_W-1:0] end_x;
    logic [Y_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [X_W-1:0]    pixel_x;
    logic [Y_W-1:0]    pixel_y;
    logic [ADDR_W-1:0] pixel_address;
    logic              last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new line and seed the divider
    logic div_step;  // one restoring-division iteration on both axes
    logic advance;   // add the increments and register a pixel
  } dda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_len;   // the offered line has equal start and end points
    logic last_step;  // the next advance emits the final pixel
  } dda_status_t;

endpackage

>>> sv/dda_datapath.sv
// ----------------------------------------------------------------------------
// DDA line stepper datapath
// Holds the fixed-point position, a two-lane restoring divider for the
// per-axis increments, the step counter and the result register.
// ----------------------------------------------------------------------------
module dda_datapath #(
  parameter int FRACTION_BITS = dda_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  dda_pkg::in_item_t   in_data,
  input  dda_pkg::dda_cmd_t   cmd,
  output dda_pkg::dda_status_t status,
  output dda_pkg::out_item_t  out_data
);

  localparam int PX_W  = dda_pkg::X_W + FRACTION_BITS;
  localparam int PY_W  = dda_pkg::Y_W + FRACTION_BITS;
  localparam int Q_W   = FRACTION_BITS + 1;
  localparam int REM_W = dda_pkg::STEP_W + 1;
  localparam logic [FRACTION_BITS-1:0] HALF = FRACTION_BITS'(1) << (FRACTION_BITS - 1);

  logic [PX_W-1:0]              pos_x_r;
  logic [PY_W-1:0]              pos_y_r;
  logic [Q_W-1:0]               quo_x_r, quo_y_r;
  logic [REM_W-1:0]             rem_x_r, rem_y_r;
  logic                         neg_x_r, neg_y_r;
  logic [dda_pkg::STEP_W-1:0]   divisor_r;
  logic [dda_pkg::STEP_W-1:0]   steps_left_r;
  dda_pkg::out_item_t           out_r;

  // Line setup: deltas, magnitudes and the step count.
  logic [dda_pkg::X_W:0]      dx, dx_abs;
  logic [dda_pkg::Y_W:0]      dy, dy_abs;
  logic [dda_pkg::STEP_W-1:0] ax, ay, steps;

  always_comb begin
    dx     = {1'b0, in_data.end_x} - {1'b0, in_data.start_x};
    dy     = {1'b0, in_data.end_y} - {1'b0, in_data.start_y};
    dx_abs = dx[dda_pkg::X_W] ? -dx : dx;
    dy_abs = dy[dda_pkg::Y_W] ? -dy : dy;
    ax     = dx_abs[dda_pkg::X_W-1:0];
    ay     = dda_pkg::STEP_W'(dy_abs[dda_pkg::Y_W-1:0]);
    steps  = (ax > ay) ? ax : ay;
  end

  // One restoring-division iteration per lane. The remainder never reaches
  // twice the divisor, so it fits one bit above the divisor width.
  logic             ge_x, ge_y;
  logic [REM_W-1:0] keep_x, keep_y;

  always_comb begin
    ge_x   = rem_x_r >= {1'b0, divisor_r};
    ge_y   = rem_y_r >= {1'b0, divisor_r};
    keep_x = ge_x ? rem_x_r - {1'b0, divisor_r} : rem_x_r;
    keep_y = ge_y ? rem_y_r - {1'b0, divisor_r} : rem_y_r;
  end

  // Position update. The position carries a half-pixel bias from load, so
  // the integer bits are already the rounded pixel.
  logic [PX_W-1:0]          pos_x_adv;
  logic [PY_W-1:0]          pos_y_adv;
  logic [dda_pkg::X_W-1:0]  px;
  logic [dda_pkg::Y_W-1:0]  py;
  logic [dda_pkg::ADDR_W-1:0] addr;

  always_comb begin
    pos_x_adv = neg_x_r ? pos_x_r - PX_W'(quo_x_r) : pos_x_r + PX_W'(quo_x_r);
    pos_y_adv = neg_y_r ? pos_y_r - PY_W'(quo_y_r) : pos_y_r + PY_W'(quo_y_r);
    px        = pos_x_adv[PX_W-1 -: dda_pkg::X_W];
    py        = pos_y_adv[PY_W-1 -: dda_pkg::Y_W];
    addr      = dda_pkg::ADDR_W'(py) * dda_pkg::ADDR_W'(dda_pkg::SCREEN_COLUMNS)
              + dda_pkg::ADDR_W'(px);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x_r      <= {in_data.start_x, HALF};
      pos_y_r      <= {in_data.start_y, HALF};
      divisor_r    <= steps;
      steps_left_r <= steps;
      rem_x_r      <= {1'b0, ax};
      rem_y_r      <= {1'b0, ay};
      quo_x_r      <= '0;
      quo_y_r      <= '0;
      neg_x_r      <= dx[dda_pkg::X_W];
      neg_y_r      <= dy[dda_pkg::Y_W];
    end
    if (cmd.div_step) begin
      rem_x_r <= {keep_x[REM_W-2:0], 1'b0};
      rem_y_r <= {keep_y[REM_W-2:0], 1'b0};
      quo_x_r <= {quo_x_r[Q_W-2:0], ge_x};
      quo_y_r <= {quo_y_r[Q_W-2:0], ge_y};
    end
    if (cmd.advance) begin
      pos_x_r               <= pos_x_adv;
      pos_y_r               <= pos_y_adv;
      steps_left_r          <= steps_left_r - 1'b1;
      out_r.pixel_x         <= px;
      out_r.pixel_y         <= py;
      out_r.pixel_address   <= addr;
      out_r.last            <= status.last_step;
    end
  end

  assign status.zero_len  = (steps == '0);
  assign status.last_step = (steps_left_r == dda_pkg::STEP_W'(1));
  assign out_data         = out_r;

endmodule

>>> sv/dda_ctrl.sv
// ----------------------------------------------------------------------------
// DDA line stepper controller
// Sequences line loads through the divider, issues pixel advances and owns
// both handshakes.
// ----------------------------------------------------------------------------
module dda_ctrl #(
  parameter int FRACTION_BITS = dda_pkg::FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_mode,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dda_pkg::dda_status_t status,
  output dda_pkg::dda_cmd_t    cmd
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LINE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  assign in_ready = (state_r != ST_DIV) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;

    unique case (state_r)
      ST_IDLE, ST_LINE: begin
        if (accept && in_mode == dda_pkg::MODE_LOAD) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = status.zero_len ? ST_IDLE : ST_DIV;
        end else if (accept && state_r == ST_LINE) begin
          cmd.advance   = 1'b1;
          out_valid_nxt = 1'b1;
          if (status.last_step) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRACTION_BITS)) begin
          state_nxt = ST_LINE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/dda_line_pixel_stepper.sv
// A step item's pixel appears in the output register in the cycle after its transfer.
// Throughput: one step item per cycle while results are taken as they appear.
// A load item of a non-empty line occupies the restoring divider (one quotient bit per
// cycle on both axes); in_ready stays low until the increments are ready.
// Reset (rst_n low, synchronous) returns the controller to idle with no result pending.
// ----------------------------------------------------------------------------
// DDA line pixel stepper
// Rasterizes a line with a fixed-point DDA: a load computes per-axis
// increments once, and each step on an active line emits the next rounded pixel.
// ----------------------------------------------------------------------------
module dda_line_pixel_stepper #(
  parameter int FRACTION_BITS = dda_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dda_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dda_pkg::out_item_t out_data
);

  // The controller decides what each transfer does; the datapath only
  // follows its commands and reports whether a line is empty and whether
  // the next pixel closes the line.
  dda_pkg::dda_cmd_t    cmd;
  dda_pkg::dda_status_t status;

  // The controller keeps in_ready low while the divider runs. Outside of
  // that, an item is taken whenever the result register is empty or is
  // being emptied in the same cycle, so a pixel stream runs at full rate.
  dda_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath stores the position with a half-pixel bias so that the
  // rounded pixel is simply the integer part after each increment. The
  // increments are kept as magnitude and sign, which truncates toward zero
  // and keeps the position between the two end points.
  dda_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

>>> sv/dda_checker.sv
// ----------------------------------------------------------------------------
// DDA line stepper checker
// Port-level assertions on the stepper, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dda_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input dda_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input dda_pkg::out_item_t out_data
);

  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // A new result only follows a transfer of a step item.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.mode == dda_pkg::MODE_STEP))
    else $error("result without a step transfer");

  // A load of a non-empty line starts the divider, which blocks the input.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.mode == dda_pkg::MODE_LOAD
      && (in_data.start_x != in_data.end_x || in_data.start_y != in_data.end_y)
    |=> !in_ready)
    else $error("input ready right after a line load");

  // Whenever a result is valid, its address matches the pixel coordinates.
  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pixel_address
      == dda_pkg::ADDR_W'(dda_pkg::ADDR_W'(out_data.pixel_y)
         * dda_pkg::ADDR_W'(dda_pkg::SCREEN_COLUMNS)
         + dda_pkg::ADDR_W'(out_data.pixel_x)))
    else $error("pixel address does not match coordinates");

endmodule

bind dda_line_pixel_stepper dda_checker u_dda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/dda_line_pixel_stepper_tb.sv
// ----------------------------------------------------------------------------
// DDA line pixel stepper testbench
// Sends line loads and step requests over the input channel, predicts every
// pixel with an in-bench fixed-point DDA, and checks each result transfer
// field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module dda_line_pixel_stepper_tb;
  import dda_pkg::*;

  // Fixed-point format of the running position, as built into the block.
  localparam int FRAC = FRACTION_BITS_DEF;
  // How long a load keeps the divider busy before in_ready rises.
  localparam int DIVIDE_CYCLES = FRAC + 1;
  // Random part stops once this many loads and pixel-producing steps went in.
  localparam int RANDOM_ITEMS = 850;
  // Length of the single long output stall used to back the block up.
  localparam int SQUEEZE_CYCLES = 300;
  // Hard stop of the run, far above the slowest legal run.
  localparam int RUN_LIMIT = 3_000_000;

  // How a directed row is checked: no result, a pixel typed into the table,
  // or whatever the in-bench DDA predicts.
  typedef enum logic [1:0] {
    CHECK_NONE,
    CHECK_PIXEL,
    CHECK_MODEL
  } row_check_t;

  typedef struct {
    in_item_t   item;
    row_check_t check;
    out_item_t  pixel;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  dda_line_pixel_stepper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Pixels that the DDA predicts, oldest first, waiting for their transfer.
  out_item_t pending_pixels[$];
  out_item_t oldest_pixel;
  stim_row_t directed_rows[$];
  int        mismatches = 0;
  int        counted_items = 0;

  // Sender pacing: bursts of random length, with stretches of no gaps at all.
  int burst_left = 0;
  bit sender_steady = 1'b0;

  // Set by the stimulus once, picked up by the receiver for its long stall.
  bit squeeze_request = 1'b0;
  bit squeeze_done = 1'b0;

  // Shadow state of the DDA. Positions and increments are signed Q.FRAC
  // values held in 64 bits so that nothing can overflow here.
  longint      dda_pos_x;
  longint      dda_pos_y;
  longint      dda_inc_x;
  longint      dda_inc_y;
  logic [9:0]  pixels_to_go;
  bit          line_busy;

  // The clock runs free from time zero.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(RUN_LIMIT);
    $display("dda_line_pixel_stepper_tb: done, errors");
    $finish;
  end

  function automatic stim_row_t row(logic mode, int sx, int sy, int ex, int ey,
                                    row_check_t chk, int px, int py, int addr,
                                    int lst);
    stim_row_t r;
    r.item.mode          = mode;
    r.item.start_x       = sx[X_W-1:0];
    r.item.start_y       = sy[Y_W-1:0];
    r.item.end_x         = ex[X_W-1:0];
    r.item.end_y         = ey[Y_W-1:0];
    r.check              = chk;
    r.pixel.pixel_x      = px[X_W-1:0];
    r.pixel.pixel_y      = py[Y_W-1:0];
    r.pixel.pixel_address = addr[ADDR_W-1:0];
    r.pixel.last         = lst[0];
    return r;
  endfunction

  function automatic int clamp_coord(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Signed increment: magnitude (|d| << FRAC) / steps truncated, then the
  // sign of d, so the increment always truncates toward zero.
  function automatic longint dda_increment(longint d, longint steps);
    longint mag;
    mag = ((d < 0 ? -d : d) << FRAC) / steps;
    return (d < 0) ? -mag : mag;
  endfunction

  // Round half up to a whole pixel; a negative position would clamp to zero.
  function automatic longint round_to_pixel(longint pos);
    longint biased;
    biased = pos + (longint'(1) << (FRAC - 1));
    if (biased < 0) return 0;
    return biased >>> FRAC;
  endfunction

  // Advances the shadow DDA by one accepted item. Returns 1 and the pixel
  // when the item produces a result.
  function automatic bit rasterize_item(input in_item_t it, output out_item_t pix);
    longint dx;
    longint dy;
    longint ax;
    longint ay;
    longint steps;
    longint px;
    longint py;
    pix = '0;
    if (it.mode == MODE_LOAD) begin
      dx = longint'(it.end_x) - longint'(it.start_x);
      dy = longint'(it.end_y) - longint'(it.start_y);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      steps = (ax > ay) ? ax : ay;
      dda_pos_x = longint'(it.start_x) << FRAC;
      dda_pos_y = longint'(it.start_y) << FRAC;
      if (steps == 0) begin
        // A zero-length line leaves the block idle.
        dda_inc_x    = 0;
        dda_inc_y    = 0;
        pixels_to_go = '0;
        line_busy    = 1'b0;
      end else begin
        dda_inc_x    = dda_increment(dx, steps);
        dda_inc_y    = dda_increment(dy, steps);
        pixels_to_go = steps[9:0];
        line_busy    = 1'b1;
      end
      return 1'b0;
    end
    // A step while idle changes nothing.
    if (!line_busy) return 1'b0;
    dda_pos_x    = dda_pos_x + dda_inc_x;
    dda_pos_y    = dda_pos_y + dda_inc_y;
    pixels_to_go = pixels_to_go - 10'd1;
    px = round_to_pixel(dda_pos_x);
    py = round_to_pixel(dda_pos_y);
    pix.pixel_x       = px[X_W-1:0];
    pix.pixel_y       = py[Y_W-1:0];
    pix.pixel_address = ADDR_W'(longint'(pix.pixel_y) * SCREEN_COLUMNS
                                + longint'(pix.pixel_x));
    pix.last          = (pixels_to_go == '0);
    if (pix.last) line_busy = 1'b0;
    return 1'b1;
  endfunction

  // A payload with every field random over its full width.
  function automatic in_item_t random_payload();
    in_item_t it;
    it.mode    = 1'($urandom_range(0, 1));
    it.start_x = X_W'($urandom_range(0, (1 << X_W) - 1));
    it.start_y = Y_W'($urandom_range(0, (1 << Y_W) - 1));
    it.end_x   = X_W'($urandom_range(0, (1 << X_W) - 1));
    it.end_y   = Y_W'($urandom_range(0, (1 << Y_W) - 1));
    return it;
  endfunction

  // Offers one item, holds it until the transfer happens, then updates the
  // shadow DDA and files the expected pixel according to the check kind.
  // The caller either offers the next item in the same time step or the next
  // call opens a gap; either way in_valid sees one assignment per step.
  task automatic transfer_item(input in_item_t it, input row_check_t chk,
                               input out_item_t typed_pixel);
    out_item_t predicted;
    bit        emits;
    if (burst_left == 0) begin
      if (!sender_steady) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 7) == 0) sender_steady = !sender_steady;
    end
    burst_left = burst_left - 1;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    emits = rasterize_item(it, predicted);
    if (chk == CHECK_PIXEL) begin
      pending_pixels.push_back(typed_pixel);
    end else if (chk == CHECK_MODEL && emits) begin
      pending_pixels.push_back(predicted);
    end
    // Steps that the block ignores do not count toward the random budget.
    if (it.mode == MODE_LOAD || emits) counted_items++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result monitor. Values are sampled at the edge, before any assignment
  // made at that edge takes effect, so the check is free of ordering races.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: pixel transfer with none expected, actual x=%0d y=%0d",
                   $time, out_data.pixel_x, out_data.pixel_y);
          mismatches++;
        end else begin
          oldest_pixel = pending_pixels.pop_front();
          check_field("pixel_x", 32'(oldest_pixel.pixel_x), 32'(out_data.pixel_x));
          check_field("pixel_y", 32'(oldest_pixel.pixel_y), 32'(out_data.pixel_y));
          check_field("pixel_address", 32'(oldest_pixel.pixel_address),
                      32'(out_data.pixel_address));
          check_field("last", 32'(oldest_pixel.last), 32'(out_data.last));
        end
      end
    end
  end

  // Receiver. It keeps switching between stall patterns: always ready, coin
  // flip, a fixed three-of-four rhythm, or mostly stalled. Once during the
  // random part it holds off for a long stretch while the sender keeps
  // offering steps, so the output register fills and in_ready drops.
  initial begin
    int rx_cycle;
    int rx_pattern;
    rx_cycle   = 0;
    rx_pattern = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_pattern = $urandom_range(0, 3);
      if (squeeze_request && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else begin
        case (rx_pattern)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (rx_cycle % 4 != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus, end of run and final verdict.
  initial begin
    in_item_t   it;
    out_item_t  no_pixel;
    int         sx;
    int         sy;
    int         ex;
    int         ey;
    int         reach;
    int         steps;
    int         n;
    int         tweak;

    no_pixel = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    dda_pos_x    = 0;
    dda_pos_y    = 0;
    dda_inc_x    = 0;
    dda_inc_y    = 0;
    pixels_to_go = '0;
    line_busy    = 1'b0;

    // Directed table. Typed pixels are the ones that fall out of whole
    // increments or an exact half; the rest are left to the DDA.
    //               mode       sx    sy   ex    ey   check        x     y    addr    last
    // Step straight out of reset, every payload bit set: nothing comes out.
    directed_rows.push_back(row(MODE_STEP, 1023, 511, 1023, 511, CHECK_NONE, 0, 0, 0, 0));
    // Zero-length line, then a step that must stay silent.
    directed_rows.push_back(row(MODE_LOAD,    5,   5,    5,   5, CHECK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0, CHECK_NONE, 0, 0, 0, 0));
    // Short horizontal line from the origin; the start pixel is skipped.
    directed_rows.push_back(row(MODE_LOAD,    0,   0,    2,   0, CHECK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0, CHECK_PIXEL, 1, 0, 1, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0, CHECK_PIXEL, 2, 0, 2, 1));
    // The line ended, so this step is ignored.
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0, CHECK_NONE, 0, 0, 0, 0));
    // Bottom-right screen corner, walking left.
    directed_rows.push_back(row(MODE_LOAD,  639, 479,  637, 479, CHECK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0,
                                CHECK_PIXEL, 638, 479, 307198, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0,
                                CHECK_PIXEL, 637, 479, 307197, 1));
    // Vertical line, cut short by a new load while still active.
    directed_rows.push_back(row(MODE_LOAD,    0,   0,    0,   3, CHECK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0, CHECK_PIXEL, 0, 1, 640, 0));
    // Off-screen coordinates at the top of the field ranges, walking back.
    directed_rows.push_back(row(MODE_LOAD, 1023, 511, 1022, 510, CHECK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0,
                                CHECK_PIXEL, 1022, 510, 327422, 1));
    // Shallow slope with a fractional minor axis.
    directed_rows.push_back(row(MODE_LOAD,    0,   0,    3,   1, CHECK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0, CHECK_MODEL, 0, 0, 0, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0, CHECK_MODEL, 0, 0, 0, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0, CHECK_MODEL, 0, 0, 0, 0));
    // Negative x on a diagonal, both axes of equal length.
    directed_rows.push_back(row(MODE_LOAD,   10,  10,    7,  13, CHECK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0, CHECK_MODEL, 0, 0, 0, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0, CHECK_MODEL, 0, 0, 0, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0, CHECK_MODEL, 0, 0, 0, 0));
    // Minor increment of exactly one half: the first pixel rounds up.
    directed_rows.push_back(row(MODE_LOAD,    0,   0,    4,   2, CHECK_NONE, 0, 0, 0, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0, CHECK_PIXEL, 1, 1, 641, 0));
    directed_rows.push_back(row(MODE_STEP,    0,   0,    0,   0, CHECK_MODEL, 0, 0, 0, 0));

    // Reset is held once, at the start of the run.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      transfer_item(directed_rows[i].item, directed_rows[i].check, directed_rows[i].pixel);
    end

    // Random part. Most of it is well-formed lines: a load followed by the
    // steps it needs, with random payload bits on the steps. Some lines are
    // cut off by the next load, some get extra steps that fall on an idle
    // block, and a small share of items is pure noise.
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      if (counted_items >= RANDOM_ITEMS / 3) squeeze_request = 1'b1;
      if ($urandom_range(0, 99) < 8) begin
        transfer_item(random_payload(), CHECK_MODEL, no_pixel);
      end else begin
        sx = $urandom_range(0, (1 << X_W) - 1);
        sy = $urandom_range(0, (1 << Y_W) - 1);
        if ($urandom_range(0, 23) == 0) begin
          // An occasional long line anywhere in the field ranges.
          ex = $urandom_range(0, (1 << X_W) - 1);
          ey = $urandom_range(0, (1 << Y_W) - 1);
        end else begin
          reach = $urandom_range(0, 24);
          ex = clamp_coord(sx + $urandom_range(0, 2 * reach) - reach, (1 << X_W) - 1);
          ey = clamp_coord(sy + $urandom_range(0, 2 * reach) - reach, (1 << Y_W) - 1);
        end
        it = random_payload();
        it.mode    = MODE_LOAD;
        it.start_x = sx[X_W-1:0];
        it.start_y = sy[Y_W-1:0];
        it.end_x   = ex[X_W-1:0];
        it.end_y   = ey[Y_W-1:0];
        transfer_item(it, CHECK_MODEL, no_pixel);

        steps = (ex > sx ? ex - sx : sx - ex);
        if ((ey > sy ? ey - sy : sy - ey) > steps) steps = (ey > sy ? ey - sy : sy - ey);
        tweak = $urandom_range(0, 9);
        if (steps > 160) n = $urandom_range(40, 160);
        else if (tweak < 2) n = $urandom_range(0, steps);
        else if (tweak == 2) n = steps + $urandom_range(1, 3);
        else n = steps;
        repeat (n) begin
          it = random_payload();
          it.mode = MODE_STEP;
          transfer_item(it, CHECK_MODEL, no_pixel);
        end
      end
    end

    // Drain: wait for every predicted pixel, then long enough for anything
    // stray, such as a late pixel after a divide, to show up.
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DIVIDE_CYCLES + 16) @(posedge clk);

    if (mismatches == 0) begin
      $display("dda_line_pixel_stepper_tb: done, clean");
    end else begin
      $display("dda_line_pixel_stepper_tb: done, errors");
    end
    $finish;
  end

endmodule
